/* src/cjss_pkg.sv */
package cjss_pkg;

    // Fixed geometry of the item.
    localparam int JOINTS      = 7;
    localparam int IN_WIDTH    = 15;
    localparam int IDX_WIDTH   = 6;
    localparam int DIST_WIDTH  = 31;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_CANDIDATES = 64;
    localparam int DEF_ANGLE_WIDTH    = 16;

    // pi and 2pi in Q3.12.
    localparam int PI_Q     = 12868;
    localparam int TWO_PI_Q = 25736;

    // Adder tree leaves: the joint count padded to a power of two.
    localparam int TREE_LEAVES = 8;

    // Decoupling queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Command codes on the input channel.
    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_CANDIDATE = 1'b1;

    typedef enum logic [0:0] {
        KIND_LOAD = 1'b0,
        KIND_CAND = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                             kind;
        logic                              last;
        logic [JOINTS-1:0][IN_WIDTH-1:0]   angles;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  last;
    } t_ctl;

endpackage

/* src/cjss_front.sv */
module cjss_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [cjss_pkg::JOINTS-1:0][cjss_pkg::IN_WIDTH-1:0] i_angles,
    input  logic                 i_last_candidate,
    output logic                 o_valid,
    output cjss_pkg::t_item      o_item,
    input  logic                 i_ready
);

    logic            r_valid;
    cjss_pkg::t_item r_item;
    cjss_pkg::t_item n_item;

    // The last mark only means something on a candidate.
    always_comb begin
        n_item.angles = i_angles;
        unique case (i_command)
            cjss_pkg::CMD_CANDIDATE: begin
                n_item.kind = cjss_pkg::KIND_CAND;
                n_item.last = i_last_candidate;
            end
            default: begin
                n_item.kind = cjss_pkg::KIND_LOAD;
                n_item.last = 1'b0;
            end
        endcase
    end

    assign o_in_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* src/cjss_queue.sv */
module cjss_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cjss_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output cjss_pkg::t_item o_item
);

    cjss_pkg::t_item                     r_slot [cjss_pkg::QUEUE_DEPTH];
    logic [cjss_pkg::QPTR_WIDTH-1:0]     r_wr_ptr;
    logic [cjss_pkg::QPTR_WIDTH-1:0]     r_rd_ptr;
    logic [cjss_pkg::QCNT_WIDTH-1:0]     r_count;
    logic                                s_push;
    logic                                s_pop;

    assign o_ready = (r_count != cjss_pkg::QCNT_WIDTH'(cjss_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign s_push  = i_valid && o_ready;
    assign s_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (s_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (s_push && !s_pop) begin
                r_count <= r_count + 1'b1;
            end else if (s_pop && !s_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* src/cjss_back.sv */
module cjss_back #(
    parameter int MAX_CANDIDATES = cjss_pkg::DEF_MAX_CANDIDATES,
    parameter int ANGLE_WIDTH    = cjss_pkg::DEF_ANGLE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  cjss_pkg::t_item                  i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [cjss_pkg::IDX_WIDTH-1:0]   o_best_index,
    output logic [cjss_pkg::DIST_WIDTH-1:0]  o_best_distance
);

    localparam int JN   = cjss_pkg::JOINTS;
    localparam int DW_N = cjss_pkg::DIST_WIDTH;
    localparam int IW   = cjss_pkg::IDX_WIDTH;
    // Difference width: wide enough for candidate minus stored angle.
    localparam int DFW  = ((ANGLE_WIDTH > cjss_pkg::IN_WIDTH) ?
                           ANGLE_WIDTH : cjss_pkg::IN_WIDTH) + 1;
    localparam int AMW  = DFW - 1;
    localparam int PW   = 2 * AMW;
    localparam int CW   = $clog2(MAX_CANDIDATES + 1);
    localparam logic signed [DFW-1:0] PI_S     = DFW'(cjss_pkg::PI_Q);
    localparam logic signed [DFW-1:0] TWO_PI_S = DFW'(cjss_pkg::TWO_PI_Q);
    localparam logic [CW-1:0]         MAX_C    = CW'(MAX_CANDIDATES);

    logic s_en;

    // Stored current position.
    logic signed [ANGLE_WIDTH-1:0] r_cur [JN];

    // Stage A: folded absolute differences.
    cjss_pkg::t_ctl   r_a_ctl;
    logic [AMW-1:0]   r_a_abs [JN];
    logic [AMW-1:0]   s_abs   [JN];

    // Stage B: squares.
    cjss_pkg::t_ctl   r_b_ctl;
    logic [DW_N-1:0]  r_b_sq  [JN];

    // Stage C and D: adder tree.
    cjss_pkg::t_ctl   r_c_ctl;
    logic [DW_N-1:0]  r_c_sum [cjss_pkg::TREE_LEAVES/2];
    logic [DW_N-1:0]  s_leaf  [cjss_pkg::TREE_LEAVES];
    cjss_pkg::t_ctl   r_d_ctl;
    logic [DW_N-1:0]  r_d_sum [2];

    // Stage E: running minimum.
    logic [DW_N-1:0]  s_dist;
    logic [DW_N-1:0]  r_min;
    logic [DW_N-1:0]  n_min;
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    n_idx;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             s_emit;

    logic             r_out_valid;
    logic [IW-1:0]    r_out_idx;
    logic [DW_N-1:0]  r_out_dist;

    // The whole pipeline advances unless a result is waiting and blocked.
    assign s_en    = !(r_out_valid && !i_ready);
    assign o_ready = s_en;

    always_comb begin
        logic signed [DFW-1:0] v_cand;
        logic signed [DFW-1:0] v_cur;
        logic signed [DFW-1:0] v_diff;
        for (int j = 0; j < JN; j++) begin
            v_cand = DFW'($signed(i_item.angles[j]));
            v_cur  = DFW'(r_cur[j]);
            v_diff = v_cand - v_cur;
            if (v_diff > PI_S) begin
                v_diff = v_diff - TWO_PI_S;
            end else if (v_diff < -PI_S) begin
                v_diff = v_diff + TWO_PI_S;
            end
            s_abs[j] = (v_diff < 0) ? AMW'(-v_diff) : AMW'(v_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < JN; j++) begin
                r_cur[j] <= '0;
            end
        end else if (s_en && i_valid && i_item.kind == cjss_pkg::KIND_LOAD) begin
            for (int j = 0; j < JN; j++) begin
                r_cur[j] <= ANGLE_WIDTH'($signed(i_item.angles[j]));
            end
        end
    end

    // Leaves of the adder tree, padded with zeros.
    always_comb begin
        s_leaf = '{default: '0};
        for (int j = 0; j < JN; j++) begin
            s_leaf[j] = r_b_sq[j];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [PW-1:0] v_prod;
        if (s_en) begin
            for (int j = 0; j < JN; j++) begin
                r_a_abs[j] <= s_abs[j];
                v_prod      = r_a_abs[j] * r_a_abs[j];
                r_b_sq[j]  <= DW_N'(v_prod);
            end
            for (int k = 0; k < cjss_pkg::TREE_LEAVES / 2; k++) begin
                r_c_sum[k] <= s_leaf[2*k] + s_leaf[2*k+1];
            end
            r_d_sum[0] <= r_c_sum[0] + r_c_sum[1];
            r_d_sum[1] <= r_c_sum[2] + r_c_sum[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            r_c_ctl <= '0;
            r_d_ctl <= '0;
        end else if (s_en) begin
            r_a_ctl.valid <= i_valid;
            r_a_ctl.kind  <= i_item.kind;
            r_a_ctl.last  <= i_item.last;
            r_b_ctl       <= r_a_ctl;
            r_c_ctl       <= r_b_ctl;
            r_d_ctl       <= r_c_ctl;
        end
    end

    assign s_dist = r_d_sum[0] + r_d_sum[1];

    // A load restarts the search; a candidate beyond the limit is counted
    // out but its last mark still closes the run.
    always_comb begin
        n_min   = r_min;
        n_idx   = r_idx;
        n_count = r_count;
        s_emit  = 1'b0;
        if (r_d_ctl.valid) begin
            if (r_d_ctl.kind == cjss_pkg::KIND_LOAD) begin
                n_min   = '0;
                n_idx   = '0;
                n_count = '0;
            end else begin
                if (r_count < MAX_C) begin
                    if (r_count == '0 || s_dist < r_min) begin
                        n_min = s_dist;
                        n_idx = IW'(r_count);
                    end
                    n_count = r_count + 1'b1;
                end
                if (r_d_ctl.last) begin
                    s_emit  = 1'b1;
                    n_count = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_en) begin
                r_min   <= n_min;
                r_idx   <= n_idx;
                r_count <= n_count;
            end
            if (s_en && s_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en && s_emit) begin
            r_out_idx  <= n_idx;
            r_out_dist <= n_min;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_best_index    = r_out_idx;
    assign o_best_distance = r_out_dist;

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_C)
        else $error("candidate count beyond limit");

    a_run_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_en && s_emit) |=> (r_count == '0 && r_out_valid))
        else $error("closing candidate did not restart the run");

    a_index_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (int'(r_out_idx) < MAX_CANDIDATES))
        else $error("best index outside the run");

    a_no_stall_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_d_ctl)))
        else $error("pipeline moved while a result was blocked");
`endif

endmodule

/* src/closest_joint_solution_select.sv */
// Throughput: one item per cycle; the back pipeline stalls only while a result
// sits unread in the output register, and a four-entry queue absorbs the front.
// Reset (synchronous, active low) clears the stored position to zero, the
// running minimum, its index and the candidate count, and empties all stages.
module closest_joint_solution_select #(
    parameter int MAX_CANDIDATES = cjss_pkg::DEF_MAX_CANDIDATES,
    parameter int ANGLE_WIDTH    = cjss_pkg::DEF_ANGLE_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_command,
    input  logic signed [cjss_pkg::IN_WIDTH-1:0]   i_angle_0,
    input  logic signed [cjss_pkg::IN_WIDTH-1:0]   i_angle_1,
    input  logic signed [cjss_pkg::IN_WIDTH-1:0]   i_angle_2,
    input  logic signed [cjss_pkg::IN_WIDTH-1:0]   i_angle_3,
    input  logic signed [cjss_pkg::IN_WIDTH-1:0]   i_angle_4,
    input  logic signed [cjss_pkg::IN_WIDTH-1:0]   i_angle_5,
    input  logic signed [cjss_pkg::IN_WIDTH-1:0]   i_angle_6,
    input  logic                                   i_last_candidate,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [cjss_pkg::IDX_WIDTH-1:0]         o_best_index,
    output logic [cjss_pkg::DIST_WIDTH-1:0]        o_best_distance
);

    // The front registers each item and tags it as a load or a candidate.
    // The queue lets the front keep taking items while the back is held by
    // an unread result. The back runs five stages: fold and magnitude of the
    // seven differences, squares, two adder tree levels, then the final add
    // together with the strict running-minimum compare.

    logic [cjss_pkg::JOINTS-1:0][cjss_pkg::IN_WIDTH-1:0] s_angles;

    logic            s_f_valid;
    logic            s_f_ready;
    cjss_pkg::t_item s_f_item;
    logic            s_q_valid;
    logic            s_q_ready;
    cjss_pkg::t_item s_q_item;

    assign s_angles[0] = i_angle_0;
    assign s_angles[1] = i_angle_1;
    assign s_angles[2] = i_angle_2;
    assign s_angles[3] = i_angle_3;
    assign s_angles[4] = i_angle_4;
    assign s_angles[5] = i_angle_5;
    assign s_angles[6] = i_angle_6;

    cjss_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_angles         (s_angles),
        .i_last_candidate (i_last_candidate),
        .o_valid          (s_f_valid),
        .o_item           (s_f_item),
        .i_ready          (s_f_ready)
    );

    cjss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_f_valid),
        .o_ready (s_f_ready),
        .i_item  (s_f_item),
        .o_valid (s_q_valid),
        .i_ready (s_q_ready),
        .o_item  (s_q_item)
    );

    // The back measures each candidate against the position stored by the
    // latest load and keeps the first of any equal distances.
    cjss_back #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .ANGLE_WIDTH    (ANGLE_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_q_valid),
        .o_ready         (s_q_ready),
        .i_item          (s_q_item),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_best_index    (o_best_index),
        .o_best_distance (o_best_distance)
    );

endmodule
